FILE: hdl/sls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sls_pkg: shared types for the sorted list store
// Opcodes, result status codes, word formats, controller states and the
// command/status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package sls_pkg;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_SEARCH = 2'd2,
    OP_DUMP   = 2'd3
  } sls_op_t;

  typedef enum logic [2:0] {
    STS_OK    = 3'd0,
    STS_DUP   = 3'd1,
    STS_FULL  = 3'd2,
    STS_MISS  = 3'd3,
    STS_ELEM  = 3'd4,
    STS_EMPTY = 3'd5
  } sls_status_t;

  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [31:0] value;
  } sls_in_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] out_value;
    logic               last;
  } sls_out_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_HEAD   = 3'd1,
    S_WALK   = 3'd2,
    S_DECIDE = 3'd3,
    S_LINK   = 3'd4
  } sls_state_t;

  // Controller -> datapath
  typedef struct packed {
    logic        load;        // latch request, restart walk and free-slot scan
    logic        head;        // take sentinel link as current node
    logic        step;        // advance: prev <= cur, cur <= link
    logic        stop;        // capture match flag and link of current node
    logic        wr_node;     // write new node into the free slot
    logic        wr_ins;      // link predecessor to the new slot
    logic        wr_del;      // unlink current node, free its slot
    logic        emit;        // present a result word next cycle
    sls_status_t emit_status;
    logic        emit_elem;   // result carries stored value, not request value
    logic        emit_last;
  } sls_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    sls_op_t opcode;
    logic    link_zero;   // link of the node just read ends the list
    logic    lt;          // node value < request value (signed)
    logic    hit;         // walk stopped on a matching node
    logic    scan_done;
    logic    free_found;
  } sls_sts_t;

endpackage
`default_nettype wire

FILE: hdl/sls_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sls_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents undefined at reset.
// ----------------------------------------------------------------------------
module sls_ram #(
  parameter  int WIDTH = 32,
  parameter  int DEPTH = 64,
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

endmodule
`default_nettype wire

FILE: hdl/sls_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sls_datapath: node store, list walker and free-slot scanner
// Holds value and link RAMs, per-slot used and link-valid bits, the walk
// pointers, a one-slot-per-cycle free scan and the result word register.
// ----------------------------------------------------------------------------
module sls_datapath #(
  parameter int STORE_SLOTS = 64
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire sls_pkg::sls_in_t  in_data,
  input  wire sls_pkg::sls_cmd_t cmd,
  output sls_pkg::sls_sts_t      sts,
  output logic                   out_valid,
  output sls_pkg::sls_out_t      out_data
);

  import sls_pkg::*;

  localparam int            W         = $clog2(STORE_SLOTS);
  localparam logic [W-1:0]  LAST_SLOT = W'(STORE_SLOTS - 1);
  localparam logic [W-1:0]  FIRST_SLOT = W'(1);

  sls_op_t            op_r, op_nxt;
  logic signed [31:0] val_r, val_nxt;
  logic [W-1:0]       cur_r, cur_nxt;
  logic [W-1:0]       prev_r, prev_nxt;
  logic [W-1:0]       slot_r, slot_nxt;
  logic [W-1:0]       nlink_r, nlink_nxt;
  logic               hit_r, hit_nxt;
  logic               scan_done_r, scan_done_nxt;
  logic               free_r, free_nxt;
  logic               lv_rd_r, lv_rd_nxt;
  logic [STORE_SLOTS-1:0] slot_used_r, slot_used_nxt;
  logic [STORE_SLOTS-1:0] link_vld_r, link_vld_nxt;
  logic               out_valid_r, out_valid_nxt;
  sls_out_t           out_data_r, out_data_nxt;

  logic signed [31:0] node_val_rd;
  logic [W-1:0]       node_link_rd;
  logic [W-1:0]       link_eff;
  logic [W-1:0]       rd_addr;
  logic               link_we;
  logic [W-1:0]       link_waddr;
  logic [W-1:0]       link_wdata;

  // unwritten link entries read as the reset value: end of list
  assign link_eff = lv_rd_r ? node_link_rd : '0;
  assign rd_addr  = (cmd.head || cmd.step) ? link_eff : '0;

  assign link_we    = cmd.wr_node || cmd.wr_ins || cmd.wr_del;
  assign link_waddr = cmd.wr_node ? slot_r : prev_r;
  assign link_wdata = cmd.wr_node ? cur_r : (cmd.wr_ins ? slot_r : nlink_r);

  sls_ram #(.WIDTH(32), .DEPTH(STORE_SLOTS)) u_val_ram (
    .clk       (clk),
    .wr_en     (cmd.wr_node),
    .wr_addr   (slot_r),
    .wr_data   (val_r),
    .rd_addr   (rd_addr),
    .rd_data_r (node_val_rd)
  );

  sls_ram #(.WIDTH(W), .DEPTH(STORE_SLOTS)) u_link_ram (
    .clk       (clk),
    .wr_en     (link_we),
    .wr_addr   (link_waddr),
    .wr_data   (link_wdata),
    .rd_addr   (rd_addr),
    .rd_data_r (node_link_rd)
  );

  always_comb begin
    op_nxt        = op_r;
    val_nxt       = val_r;
    cur_nxt       = cur_r;
    prev_nxt      = prev_r;
    slot_nxt      = slot_r;
    nlink_nxt     = nlink_r;
    hit_nxt       = hit_r;
    scan_done_nxt = scan_done_r;
    free_nxt      = free_r;
    slot_used_nxt = slot_used_r;
    link_vld_nxt  = link_vld_r;

    if (cmd.load) begin
      op_nxt        = sls_op_t'(in_data.opcode);
      val_nxt       = in_data.value;
      prev_nxt      = '0;
      hit_nxt       = 1'b0;
      slot_nxt      = FIRST_SLOT;
      scan_done_nxt = 1'b0;
      free_nxt      = 1'b0;
    end else if (!scan_done_r) begin
      // one slot per cycle, lowest first
      if (!slot_used_r[slot_r]) begin
        scan_done_nxt = 1'b1;
        free_nxt      = 1'b1;
      end else if (slot_r == LAST_SLOT) begin
        scan_done_nxt = 1'b1;
      end else begin
        slot_nxt = slot_r + FIRST_SLOT;
      end
    end

    if (cmd.head) begin
      cur_nxt = link_eff;
    end
    if (cmd.step) begin
      prev_nxt = cur_r;
      cur_nxt  = link_eff;
    end
    if (cmd.stop) begin
      hit_nxt   = (node_val_rd == val_r);
      nlink_nxt = link_eff;
    end

    if (cmd.wr_node) begin
      slot_used_nxt[slot_r] = 1'b1;
    end
    if (cmd.wr_del) begin
      slot_used_nxt[cur_r] = 1'b0;
    end
    if (link_we) begin
      link_vld_nxt[link_waddr] = 1'b1;
    end
  end

  assign lv_rd_nxt     = link_vld_nxt[rd_addr] & link_vld_r[rd_addr];
  assign out_valid_nxt = cmd.emit;

  always_comb begin
    out_data_nxt.status    = cmd.emit_status;
    out_data_nxt.out_value = cmd.emit_elem ? node_val_rd : val_r;
    out_data_nxt.last      = cmd.emit_last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_done_r <= 1'b1;
      free_r      <= 1'b0;
      lv_rd_r     <= 1'b0;
      out_valid_r <= 1'b0;
      slot_used_r <= STORE_SLOTS'(1);
      link_vld_r  <= '0;
    end else begin
      scan_done_r <= scan_done_nxt;
      free_r      <= free_nxt;
      lv_rd_r     <= lv_rd_nxt;
      out_valid_r <= out_valid_nxt;
      slot_used_r <= slot_used_nxt;
      link_vld_r  <= link_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r       <= op_nxt;
    val_r      <= val_nxt;
    cur_r      <= cur_nxt;
    prev_r     <= prev_nxt;
    slot_r     <= slot_nxt;
    nlink_r    <= nlink_nxt;
    hit_r      <= hit_nxt;
    out_data_r <= out_data_nxt;
  end

  always_comb begin
    sts.opcode     = op_r;
    sts.link_zero  = (link_eff == '0);
    sts.lt         = (node_val_rd < val_r);
    sts.hit        = hit_r;
    sts.scan_done  = scan_done_r;
    sts.free_found = free_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

FILE: hdl/sls_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sls_ctrl: sequencer for the sorted list store
// Walks one node per cycle, then decides and commits; a dump emits each node.
// ----------------------------------------------------------------------------
module sls_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire sls_pkg::sls_sts_t sts,
  output sls_pkg::sls_cmd_t      cmd
);

  import sls_pkg::*;

  sls_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_HEAD;
      end
      S_HEAD: begin
        if (sts.link_zero) begin
          state_nxt = (sts.opcode == OP_DUMP) ? S_IDLE : S_DECIDE;
        end else begin
          state_nxt = S_WALK;
        end
      end
      S_WALK: begin
        if (sts.opcode == OP_DUMP) begin
          if (sts.link_zero) state_nxt = S_IDLE;
        end else if (!sts.lt || sts.link_zero) begin
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        if (sts.opcode == OP_INSERT) begin
          if (sts.hit) begin
            state_nxt = S_IDLE;
          end else if (sts.scan_done) begin
            state_nxt = sts.free_found ? S_LINK : S_IDLE;
          end
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_LINK:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd             = '0;
    cmd.emit_status = STS_OK;
    busy            = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        cmd.load = start;
      end
      S_HEAD: begin
        cmd.head = 1'b1;
        if (sts.opcode == OP_DUMP && sts.link_zero) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = STS_EMPTY;
          cmd.emit_last   = 1'b1;
        end
      end
      S_WALK: begin
        if (sts.opcode == OP_DUMP) begin
          cmd.step        = 1'b1;
          cmd.emit        = 1'b1;
          cmd.emit_status = STS_ELEM;
          cmd.emit_elem   = 1'b1;
          cmd.emit_last   = sts.link_zero;
        end else if (sts.lt) begin
          cmd.step = 1'b1;
        end else begin
          cmd.stop = 1'b1;
        end
      end
      S_DECIDE: begin
        case (sts.opcode)
          OP_INSERT: begin
            if (sts.hit) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = STS_DUP;
              cmd.emit_last   = 1'b1;
            end else if (sts.scan_done && !sts.free_found) begin
              cmd.emit        = 1'b1;
              cmd.emit_status = STS_FULL;
              cmd.emit_last   = 1'b1;
            end else if (sts.scan_done) begin
              cmd.wr_node = 1'b1;
            end
          end
          OP_DELETE: begin
            cmd.wr_del      = sts.hit;
            cmd.emit        = 1'b1;
            cmd.emit_status = sts.hit ? STS_OK : STS_MISS;
            cmd.emit_last   = 1'b1;
          end
          OP_SEARCH: begin
            cmd.emit        = 1'b1;
            cmd.emit_status = sts.hit ? STS_OK : STS_MISS;
            cmd.emit_last   = 1'b1;
          end
          default: begin
            cmd.emit = 1'b0;
          end
        endcase
      end
      S_LINK: begin
        cmd.wr_ins      = 1'b1;
        cmd.emit        = 1'b1;
        cmd.emit_status = STS_OK;
        cmd.emit_last   = 1'b1;
      end
      default: begin
        cmd.load = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: hdl/sorted_list_store_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_list_store_unit: sorted set of signed 32-bit values in a linked list
//
// Usage:
//   Input word (opcode, value) is taken at a rising edge with start high and
//   busy low. Opcodes: insert, delete, search, dump. Each result word is on
//   out_data for exactly one cycle with out_valid high; the receiver cannot
//   stall, so there is no back-pressure on the result side. out_data.last
//   marks the final result of an operation.
//   Sequencing: one operation at a time. Accept, head, one walk step per
//   list node visited (the walk stops at the first node not below the
//   value), decide, plus a link step for a successful insert. The walk is
//   set by the value/link RAM read port. An insert also waits for the
//   free-slot scan, one slot per cycle in parallel with the walk. A dump
//   delivers one result per cycle. The next word may be accepted in the
//   cycle the last result is shown.
//   Reset: synchronous, active low; the list is empty right after reset,
//   with no clearing pass (per-slot valid bits stand in for cleared links).
// ----------------------------------------------------------------------------
module sorted_list_store_unit #(
  parameter int STORE_SLOTS = 64
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire sls_pkg::sls_in_t in_data,
  output logic                  out_valid,
  output sls_pkg::sls_out_t     out_data
);

  import sls_pkg::*;

  sls_cmd_t cmd;
  sls_sts_t sts;

  // sequencer: walk, decide, commit
  sls_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  // node store, pointers, free scan and result register
  sls_datapath #(.STORE_SLOTS(STORE_SLOTS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
